>>> hdl/dbe_pkg.sv
// ----------------------------------------------------------------------------
// dbe_pkg: shared types for the integrating debouncer with edge events
// Request/result payloads, action codes, configuration register indexes.
// ----------------------------------------------------------------------------
package dbe_pkg;

	localparam int CntW  = 16;
	localparam int TimeW = 32;
	localparam int CfgDataW = 32;

	// Register reset values
	localparam logic [CntW-1:0]  DebounceCountRst = CntW'(5);
	localparam logic             ActiveLevelRst   = 1'b1;
	localparam logic [TimeW-1:0] LongLimitRst     = '0;

	// Action codes carried by a request
	typedef enum logic [2:0] {
		ACT_SAMPLE      = 3'd0,
		ACT_TAKE_RISE   = 3'd1,
		ACT_TAKE_FALL   = 3'd2,
		ACT_TAKE_ANY    = 3'd3,
		ACT_HIGH_LONG   = 3'd4,
		ACT_LOW_LONG    = 3'd5,
		ACT_IGNORE_RISE = 3'd6,
		ACT_IGNORE_FALL = 3'd7
	} action_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_DEBOUNCE_COUNT = 2'd0,
		REG_ACTIVE_LEVEL   = 2'd1,
		REG_HIGH_LIMIT     = 2'd2,
		REG_LOW_LIMIT      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		action_t          action;
		logic             pin_level;
		logic [TimeW-1:0] now_ms;
	} in_req_t;

	typedef struct packed {
		logic             answer;
		logic             debounced_level;
		logic [TimeW-1:0] high_time_ms;
		logic [TimeW-1:0] low_time_ms;
	} out_res_t;

	// Current configuration, handed from the register file to the core
	typedef struct packed {
		logic [CntW-1:0]  debounce_count;
		logic             active_level;
		logic [TimeW-1:0] high_long_limit_ms;
		logic [TimeW-1:0] low_long_limit_ms;
	} cfg_t;

endpackage

>>> hdl/integrating_debouncer_edge_events.sv
// ----------------------------------------------------------------------------
// integrating_debouncer_edge_events: top level
// Input register, debounce core and output register with valid/ready on both
// sides, plus the configuration register file.
//
//   Channel   Signals                          Payload
//   in        in_valid / in_ready              in_data  (in_req_t)
//   out       out_valid / out_ready            out_data (out_res_t)
//   cfg       cfg_wr_en, cfg_index, cfg_data   32-bit register write
//
// One request per cycle sustained while the output is not stalled; an accepted
// request is held in the input register, then moves to the result register.
// The core update is a single 16-bit counter step and 32-bit subtracts and
// compares, done between the input register and the result register.
// A stalled output holds its result; the input register accepts while it is
// empty, or while the result register is free or being drained in that cycle.
// Reset clears all debounce state and loads register defaults.
// ----------------------------------------------------------------------------
module integrating_debouncer_edge_events
	import dbe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_req_t             in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_res_t            out_data,
	input  logic                cfg_wr_en,
	input  reg_idx_t            cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	in_req_t  req_s1;
	logic     valid_s1;
	out_res_t res_q;
	logic     out_valid_q;
	out_res_t res_n;
	cfg_t     cfg;
	logic     advance;

	// Move stage 1 into the result register when it is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	dbe_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dbe_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (req_s1),
		.cfg    (cfg),
		.res    (res_n)
	);

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_data;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = res_q;

`ifndef SYNTHESIS
	// An accepted request lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted request not held in stage 1");

	// Stage 1 is never overwritten while it cannot advance
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(req_s1)))
		else $error("stage 1 request lost while stalled");

	// A processed request always produces a result
	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed request produced no result");
`endif

endmodule

>>> hdl/dbe_cfg_regs.sv
// ----------------------------------------------------------------------------
// dbe_cfg_regs: configuration register file
// Plain write port, no read-back; fields truncated to register width.
// ----------------------------------------------------------------------------
module dbe_cfg_regs
	import dbe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  reg_idx_t            cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_count     <= DebounceCountRst;
			cfg_q.active_level       <= ActiveLevelRst;
			cfg_q.high_long_limit_ms <= LongLimitRst;
			cfg_q.low_long_limit_ms  <= LongLimitRst;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DEBOUNCE_COUNT: cfg_q.debounce_count     <= cfg_data[CntW-1:0];
				REG_ACTIVE_LEVEL:   cfg_q.active_level       <= cfg_data[0];
				REG_HIGH_LIMIT:     cfg_q.high_long_limit_ms <= cfg_data[TimeW-1:0];
				REG_LOW_LIMIT:      cfg_q.low_long_limit_ms  <= cfg_data[TimeW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/dbe_core.sv
// ----------------------------------------------------------------------------
// dbe_core: debounce state and per-request update
// Holds counter, level, pending/ignore flags and edge stamps; computes the
// next state and the result for one request in a single pass.
// ----------------------------------------------------------------------------
module dbe_core
	import dbe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_req_t  req,
	input  cfg_t     cfg,
	output out_res_t res
);

	logic [CntW-1:0]  counter_q, counter_n;
	logic             level_q, level_n;
	logic             rise_pend_q, rise_pend_n;
	logic             fall_pend_q, fall_pend_n;
	logic             any_pend_q, any_pend_n;
	logic             ign_rise_q, ign_rise_n;
	logic             ign_fall_q, ign_fall_n;
	logic [TimeW-1:0] rise_stamp_q, rise_stamp_n;
	logic [TimeW-1:0] fall_stamp_q, fall_stamp_n;
	logic             answer;

	logic [CntW-1:0]  cnt_smp;
	logic [TimeW-1:0] rise_age, fall_age;
	logic             is_rise, is_fall;

	// Sample path: saturating up/down counter and edge detection
	always_comb begin
		cnt_smp = counter_q;
		if (req.pin_level == cfg.active_level) begin
			if (counter_q < cfg.debounce_count) cnt_smp = counter_q + 1'b1;
		end else begin
			if (counter_q != '0) cnt_smp = counter_q - 1'b1;
		end
		is_rise = (cnt_smp >= cfg.debounce_count) && !level_q;
		is_fall = (cnt_smp == '0) && level_q;
	end

	assign rise_age = req.now_ms - rise_stamp_q;
	assign fall_age = req.now_ms - fall_stamp_q;

	// Next state and answer per action
	always_comb begin
		counter_n    = counter_q;
		level_n      = level_q;
		rise_pend_n  = rise_pend_q;
		fall_pend_n  = fall_pend_q;
		any_pend_n   = any_pend_q;
		ign_rise_n   = ign_rise_q;
		ign_fall_n   = ign_fall_q;
		rise_stamp_n = rise_stamp_q;
		fall_stamp_n = fall_stamp_q;
		answer       = 1'b0;
		unique case (req.action)
			ACT_SAMPLE: begin
				counter_n = cnt_smp;
				if (is_rise) begin
					if (ign_rise_q) ign_rise_n = 1'b0;
					else            rise_pend_n = 1'b1;
					any_pend_n   = 1'b1;
					level_n      = 1'b1;
					rise_stamp_n = req.now_ms;
					fall_stamp_n = '0;
				end
				if (is_fall) begin
					if (ign_fall_q) ign_fall_n = 1'b0;
					else            fall_pend_n = 1'b1;
					any_pend_n   = 1'b1;
					level_n      = 1'b0;
					fall_stamp_n = req.now_ms;
					rise_stamp_n = '0;
				end
			end
			ACT_TAKE_RISE: begin
				if (rise_pend_q) begin
					rise_pend_n = 1'b0;
					any_pend_n  = 1'b0;
					answer      = !ign_rise_q;
				end
			end
			ACT_TAKE_FALL: begin
				if (fall_pend_q) begin
					fall_pend_n = 1'b0;
					any_pend_n  = 1'b0;
					answer      = !ign_fall_q;
				end
			end
			ACT_TAKE_ANY: begin
				answer     = any_pend_q;
				any_pend_n = 1'b0;
			end
			ACT_HIGH_LONG: begin
				if ((rise_stamp_q != '0) && (rise_age >= cfg.high_long_limit_ms)) begin
					rise_stamp_n = '0;
					answer       = 1'b1;
				end
			end
			ACT_LOW_LONG: begin
				if ((fall_stamp_q != '0) && (fall_age >= cfg.low_long_limit_ms)) begin
					fall_stamp_n = '0;
					answer       = 1'b1;
				end
			end
			ACT_IGNORE_RISE: ign_rise_n = 1'b1;
			ACT_IGNORE_FALL: ign_fall_n = 1'b1;
			default: ;
		endcase
	end

	// Result from the state after this request
	always_comb begin
		res.answer          = answer;
		res.debounced_level = level_n;
		res.high_time_ms    = level_n ? (req.now_ms - rise_stamp_n) : '0;
		res.low_time_ms     = level_n ? '0 : (req.now_ms - fall_stamp_n);
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q    <= '0;
			level_q      <= 1'b0;
			rise_pend_q  <= 1'b0;
			fall_pend_q  <= 1'b0;
			any_pend_q   <= 1'b0;
			ign_rise_q   <= 1'b0;
			ign_fall_q   <= 1'b0;
			rise_stamp_q <= '0;
			fall_stamp_q <= '0;
		end else if (step) begin
			counter_q    <= counter_n;
			level_q      <= level_n;
			rise_pend_q  <= rise_pend_n;
			fall_pend_q  <= fall_pend_n;
			any_pend_q   <= any_pend_n;
			ign_rise_q   <= ign_rise_n;
			ign_fall_q   <= ign_fall_n;
			rise_stamp_q <= rise_stamp_n;
			fall_stamp_q <= fall_stamp_n;
		end
	end

`ifndef SYNTHESIS
	// State moves only on a processed request
	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> ($stable(level_q) && $stable(counter_q) && $stable(any_pend_q)))
		else $error("debounce state changed without a request");

	// Only a sample can move the debounced level
	a_level_by_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(step && req.action != ACT_SAMPLE) |=> $stable(level_q))
		else $error("debounced level changed on a non-sample action");

	// Every level change raises the any-edge flag
	a_edge_sets_any: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(level_q) || $fell(level_q)) |-> any_pend_q)
		else $error("level edge without any-edge flag");
`endif

endmodule
